FILE: design/sha256_stream_hash_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef SHA256_STREAM_HASH_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASH_UNIT_ASSERT_SVH

// Implication checked every clock outside reset.
`define SHU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock outside reset.
`define SHU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sha_pkg.sv
package sha_pkg;

  localparam int QueueDepth = 4;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } cmd_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

endpackage

FILE: design/sha_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: design/sha_front.sv
module sha_front
  import sha_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  sha_in_if.sink     in_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_take
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  // Drop idle words at the door; only bytes and message ends go back.
  assign in_ch.ready = (count != (AW+1)'(Depth));
  assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
  assign pop  = cmd_take && (count != '0);
  assign cmd_valid = (count != '0);
  assign cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data_byte: in_ch.data_byte, has_byte: in_ch.has_byte,
                       end_of_message: in_ch.end_of_message};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: design/sha_core.sv
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_take,
  sha_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_BYTE, S_PAD, S_COMP, S_ADD, S_EMIT
  } state_t;

  state_t      state;
  logic [31:0] buf_mem [16];
  logic [5:0]  fill;
  logic [63:0] length_bits;
  logic [63:0] total;
  logic [7:0]  cur_byte;
  logic        cur_eom;
  logic        finishing;
  logic        pad_started;
  logic        len_ok;
  logic [31:0] hw [8];
  logic [31:0] r  [8];
  logic [31:0] w  [16];
  logic [5:0]  round;
  logic [3:0]  load_idx;
  logic        loading;
  logic [2:0]  emit_idx;

  logic [31:0] t1, t2, s0, s1, wnew, wcur;
  logic [7:0]  pad_byte;

  // Schedule word for this round is the window head; a fresh expansion refills the window tail.
  always_comb begin
    s0   = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1   = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    wcur = w[0];
    t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
       + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RK[round] + wcur;
    t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
       + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
  end

  // Marker first, then zeros; the length goes into bytes 56..63 only of the
  // block that can still hold it.
  always_comb begin
    if (!pad_started) pad_byte = PadByte;
    else if (len_ok && fill[5:3] == 3'b111) pad_byte = total[{~fill[2:0], 3'b111} -: 8];
    else pad_byte = '0;
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_word = hw[emit_idx];
  assign out_ch.word_index = emit_idx;
  assign out_ch.last_word = (emit_idx == 3'd7);

  // Block store: one byte written per cycle in the byte and pad states, one word read per cycle while loading.
  logic       bwe;
  logic [5:0] baddr;
  logic [7:0] bdata;
  always_comb begin
    bwe   = (state == S_BYTE) || (state == S_PAD);
    baddr = fill;
    bdata = (state == S_BYTE) ? cur_byte : pad_byte;
  end
  always_ff @(posedge clk) begin
    if (bwe) buf_mem[baddr[5:2]][{~baddr[1:0], 3'b000} +: 8] <= bdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      length_bits <= '0;
      pad_started <= 1'b0;
      len_ok      <= 1'b0;
      finishing   <= 1'b0;
      emit_idx    <= '0;
      round       <= '0;
      load_idx    <= '0;
      loading     <= 1'b0;
      for (int i = 0; i < 8; i++) hw[i] <= IV[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_byte <= cmd.data_byte;
            cur_eom  <= cmd.end_of_message;
            if (cmd.has_byte) begin
              state <= S_BYTE;
              length_bits <= length_bits + 64'd8;
            end else begin
              state <= S_PAD;
              total <= length_bits;
              finishing <= 1'b1;
              pad_started <= 1'b0;
            end
          end
        end
        S_BYTE: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_COMP;
            loading <= 1'b1;
            load_idx <= '0;
            finishing <= cur_eom;
            pad_started <= 1'b0;
            total <= length_bits;
          end else if (cur_eom) begin
            state <= S_PAD;
            finishing <= 1'b1;
            pad_started <= 1'b0;
            total <= length_bits;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          pad_started <= 1'b1;
          if (!pad_started && fill < 6'd56) len_ok <= 1'b1;
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_COMP;
            loading <= 1'b1;
            load_idx <= '0;
          end
        end
        S_COMP: begin
          if (loading) begin
            // Gather the block into the schedule window, one word a cycle.
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= buf_mem[load_idx];
            load_idx <= load_idx + 4'd1;
            if (load_idx == 4'd15) begin
              loading <= 1'b0;
              round <= '0;
              for (int i = 0; i < 8; i++) r[i] <= hw[i];
            end
          end else begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= wnew;
            r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4];
            r[4] <= r[3] + t1;
            r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0];
            r[0] <= t1 + t2;
            round <= round + 6'd1;
            if (round == 6'd63) state <= S_ADD;
          end
        end
        S_ADD: begin
          // Fold the working words into the hash words, then pick the next step.
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + r[i];
          if (!finishing) begin
            state <= S_IDLE;
          end else if (pad_started && len_ok) begin
            state <= S_EMIT;
            emit_idx <= '0;
          end else begin
            state <= S_PAD;
            if (pad_started) len_ok <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state <= S_IDLE;
              fill <= '0;
              length_bits <= '0;
              finishing <= 1'b0;
              pad_started <= 1'b0;
              len_ok <= 1'b0;
              for (int i = 0; i < 8; i++) hw[i] <= IV[i];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/sha256_stream_hash_unit.sv
// SHA-256 stream hash: one message byte per input word, eight digest words out.
// Each byte is taken from the queue, then stored; a full 64-byte block is
// compressed before the next take: 16 word loads, 64 rounds, a fold into hash words.
// After the end word: the take, padding and one compression, or two compressions
// with one or two padding passes, then one digest word a cycle while ready is high.
// Reset (rst, synchronous): hash words to initial values, counts cleared, queue empty.
module sha256_stream_hash_unit
  import sha_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  // Front: accept and filter words into a short queue.
  sha_front #(.Depth(Depth)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  // Back: buffer, pad, compress and emit the digest.
  sha_core u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .out_ch(out_ch)
  );

endmodule

FILE: design/sha_checker.sv
`include "sha256_stream_hash_unit_assert.svh"

module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHU_ASSERT_IMP(a_last_idx, clk, rst, out_valid, (last_word == (word_index == 3'd7)), "last_word mismatch")
  `SHU_ASSERT_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1), "index not advancing")
  `SHU_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(word_index), "stalled word changed")

endmodule

bind sha256_stream_hash_unit sha_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sha_pkg::*;

  logic clk;
  logic rst;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hash_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // One expected digest word.
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_exp_t;

  // Round constants and initial hash values, kept locally for prediction.
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [7:0] MarkByte = 8'h80;
  localparam int WatchLimit = 20000;
  localparam int LongHold = 400;
  localparam int ItemCount = 270;

  // Predictor state: chaining words, block store, fill position, bit length.
  logic [31:0] chain_h [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill_pos;
  logic [63:0] bit_len;

  digest_exp_t digest_q [$];
  cmd_t        pending_q [$];

  int errors;
  int words_seen;
  int msgs_done;
  int bytes_sent;
  bit stim_done;
  bit hold_long;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) chain_h[i] = StartHash[i];
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill_pos = '0;
    bit_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += r[i];
  endtask

  task automatic push_block_byte(input logic [7:0] b);
    blk[fill_pos] = b;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 0) compress_block();
  endtask

  // Advance the predictor by one accepted word; queue digest words at message end.
  task automatic predict_digest(input cmd_t c);
    logic [63:0] total;
    digest_exp_t e;
    if (c.has_byte) begin
      bit_len = bit_len + 64'd8;
      push_block_byte(c.data_byte);
    end
    if (c.end_of_message) begin
      total = bit_len;
      push_block_byte(MarkByte);
      while (fill_pos != 6'd56) push_block_byte(8'h00);
      for (int i = 0; i < 8; i++) push_block_byte(total[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        e.digest_word = chain_h[i];
        e.word_index = 3'(i);
        e.last_word = (i == 7);
        digest_q = {digest_q, e};
      end
      hash_reset();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("tb: mismatch %s got %h expected %h at %0t", what, got, want, $time);
  endtask

  // Queue helpers: a message of n random bytes, last byte optionally riding the end.
  task automatic add_word(input logic [7:0] d, input bit hb, input bit eom);
    cmd_t c;
    c.data_byte = d;
    c.has_byte = hb;
    c.end_of_message = eom;
    pending_q = {pending_q, c};
    if (hb) bytes_sent++;
  endtask

  task automatic add_message(input int n, input bit end_with_byte, input bit noise);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 7) == 0) add_word(8'($urandom), 1'b0, 1'b0);
      add_word(8'($urandom), 1'b1, end_with_byte && (i == n - 1));
    end
    if (!end_with_byte || n == 0) add_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill the stimulus queue: directed messages first, then random ones.
  initial begin
    int n;
    errors = 0; words_seen = 0; msgs_done = 0; bytes_sent = 0;
    stim_done = 0;
    hash_reset();
    // empty message, with and without an idle word before the end
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'hff, 1'b0, 1'b1);
    // single byte extremes, byte carried on the end word
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'hff, 1'b1, 1'b1);
    // "abc" with a separate end word
    add_word(8'h61, 1'b1, 1'b0);
    add_word(8'h62, 1'b1, 1'b0);
    add_word(8'h63, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    // lengths around the one/two block padding boundary
    add_message(55, 1'b1, 1'b0);
    add_message(56, 1'b1, 1'b0);
    add_message(64, 1'b0, 1'b0);
    // random messages, mostly short, a few longer ones
    while (pending_q.size() < ItemCount) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
      if (n > ItemCount - pending_q.size()) n = ItemCount - pending_q.size();
      add_message(n, $urandom_range(0, 1), 1'b1);
    end
  end

  // Reset and initial levels.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Acceptance is sampled at the rising edge; the driver reacts on the falling edge.
  bit in_fire, out_fire;
  always @(posedge clk) begin
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
  end

  // Driver: present words at the falling edge with random gaps.
  int gap_left;
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      gap_left = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        c = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= c.data_byte;
        in_ch.has_byte <= c.has_byte;
        in_ch.end_of_message <= c.end_of_message;
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0) gap_left = 0;
      end else begin
        in_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted input word, check each accepted output word.
  always @(posedge clk) begin
    cmd_t c;
    digest_exp_t e;
    if (!rst && in_ch.valid && in_ch.ready) begin
      c.data_byte = in_ch.data_byte;
      c.has_byte = in_ch.has_byte;
      c.end_of_message = in_ch.end_of_message;
      predict_digest(c);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        report("unexpected word", out_ch.digest_word, 32'h0);
      end else begin
        e = digest_q.pop_front();
        if (out_ch.digest_word !== e.digest_word)
          report("digest_word", out_ch.digest_word, e.digest_word);
        if (out_ch.word_index !== e.word_index)
          report("word_index", 32'(out_ch.word_index), 32'(e.word_index));
        if (out_ch.last_word !== e.last_word)
          report("last_word", 32'(out_ch.last_word), 32'(e.last_word));
        if (e.last_word) msgs_done++;
      end
    end
  end

  // Receiver: random stall per word, one long hold-off early in the run.
  int rdy_wait;
  int hold_cnt;
  always @(negedge clk) begin
    if (rst) begin
      rdy_wait = 0;
      hold_cnt = 0;
      hold_long = 1'b0;
    end else if (!hold_long && msgs_done == 3 && hold_cnt == 0) begin
      hold_long = 1'b1;
      hold_cnt = LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= (hold_cnt == 0);
    end else if (out_fire || !out_ch.ready) begin
      if (rdy_wait > 0) begin
        rdy_wait = rdy_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rdy_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    while (!(stim_done && digest_q.size() == 0 && !in_ch.valid)) begin
      @(posedge clk);
      if (in_fire || out_fire || hold_cnt > 0) idle = 0;
      else idle++;
      if (idle >= WatchLimit) begin
        $display("tb: timeout, %0d digest words still expected", digest_q.size());
        $display("tb: failure");
        $finish;
      end
    end
    // let any trailing output show up as an unexpected word
    repeat (300) @(posedge clk);
    $display("tb: %0d message bytes hashed over %0d messages, %0d digest words checked",
             bytes_sent, msgs_done, words_seen);
    $display("tb: covered empty and padding-boundary messages, idle words and a long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
